// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the phase busy-time accounter (used by its top level).
// Expects clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define PBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pba_pkg.sv =====
// Shared types, constants and helper functions of the phase busy-time accounter.
// No dependencies.
`default_nettype none

package pba_pkg;

  localparam int PhaseClasses = 32;
  localparam int CountBits    = 16;
  localparam int ClassIdxW    = (PhaseClasses > 1) ? $clog2(PhaseClasses) : 1;
  localparam int TotalW       = CountBits + ClassIdxW;

  localparam logic [CountBits-1:0] CountMax = '1;

  localparam logic [2:0] ReqOpen  = 3'd0;
  localparam logic [2:0] ReqClose = 3'd1;
  localparam logic [2:0] ReqAdd   = 3'd2;
  localparam logic [2:0] ReqRead  = 3'd3;
  localparam logic [2:0] ReqClear = 3'd4;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StRange  = 2'd1;
  localparam logic [1:0] StNoOpen = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  phase;
    logic [63:0] timestamp;
    logic [63:0] cpu_amount;
  } pba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] cpu_total;
    logic [31:0] run_total;
    logic [63:0] wall_total;
    logic [15:0] peak_active;
    logic [63:0] busy_total;
    logic        any_active;
  } pba_out_t;

  typedef struct packed {
    logic [CountBits-1:0] active;
    logic [CountBits-1:0] peak;
    logic [63:0]          stamp;
    logic [63:0]          wall;
    logic [63:0]          cpu;
    logic [31:0]          run;
  } pba_row_t;

  typedef struct packed {
    logic load;
    logic commit;
  } pba_cmd_t;

  function automatic logic [15:0] peak_sat(input logic [CountBits-1:0] pk);
    logic [31:0] p32;
    p32 = 32'(pk);
    return (p32 > 32'h0000_ffff) ? 16'hffff : p32[15:0];
  endfunction

  function automatic logic [63:0] elapsed(input logic [63:0] from_t, input logic [63:0] to_t);
    return (to_t > from_t) ? (to_t - from_t) : 64'd0;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/phase_busy_time_accounter.sv =====
// Phase busy-time accounter: request channel in, one result per request out.
// Usage
//   Request channel: in_valid_i / in_stall_o with an in_data_i payload
//   (request type, phase class, time stamp, cpu amount). Result channel:
//   out_valid_o / out_stall_i with an out_data_o payload (status, class row,
//   busy total, any-active flag). A transfer happens when valid is high and
//   stall is low at a rising edge.
//   A transferred request and its class row are registered first; the result
//   goes to the output register in the update step once that register is free.
//   The block takes no new request before the current one is committed, set
//   by the read then write of the class row memory (registered read, one port).
//   The block takes a new request while the previous result still waits.
//   When the receiver stalls, the result holds, and a following request
//   waits in the update step until the output register frees up.
//   Reset clears all class rows through per-class valid bits, the global
//   holder count and the busy total at once; no clearing pass is needed.
// Depends on pba_pkg, pba_ctrl, pba_datapath and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module phase_busy_time_accounter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pba_pkg::pba_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pba_pkg::pba_out_t      out_data_o
);

  pba_pkg::pba_cmd_t cmd;
  logic              in_xfer;
  logic              out_room;
  logic              range_out;
  logic              row_zero;

  pba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pba_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_room  = !out_valid_o || !out_stall_i;
  assign range_out = out_valid_o && (out_data_o.status == pba_pkg::StRange);
  assign row_zero  = (out_data_o.cpu_total == 64'd0) && (out_data_o.peak_active == 16'd0);

  `PBA_ASSERT_NEXT(a_busy_after_accept, in_xfer, in_stall_o, "accept did not block input")
  `PBA_ASSERT_IMPL(a_commit_needs_room, cmd.commit, out_room, "commit over a stalled result")
  `PBA_ASSERT_IMPL(a_range_row_zero, range_out, row_zero, "out-of-range result has a row")

endmodule

`default_nettype wire

// ===== hw/rtl/pba_ctrl.sv =====
// Controller of the phase busy-time accounter: request sequencing and output valid.
// Depends on pba_pkg.
`default_nettype none

module pba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output pba_pkg::pba_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.commit = (state_q == S_EXEC) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pba_datapath.sv =====
// Datapath of the phase busy-time accounter: class row memory, global counters,
// update logic and result register. Depends on pba_pkg.
`default_nettype none

module pba_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pba_pkg::pba_cmd_t cmd_i,
  input  wire pba_pkg::pba_in_t  in_data_i,
  output pba_pkg::pba_out_t      out_data_o
);

  pba_pkg::pba_in_t  req_q;
  pba_pkg::pba_row_t row_mem [pba_pkg::PhaseClasses];
  pba_pkg::pba_row_t rd_row_q;
  logic              rd_vld_q;
  logic [pba_pkg::PhaseClasses-1:0] row_vld_q;

  logic [pba_pkg::TotalW-1:0] total_q, total_d;
  logic [63:0] busy_stamp_q, busy_stamp_d;
  logic [63:0] busy_acc_q, busy_acc_d;
  pba_pkg::pba_out_t out_q, out_d;

  pba_pkg::pba_row_t row_cur, row_d;
  logic [pba_pkg::CountBits-1:0] act_inc;
  logic row_we;
  logic vld_clear;
  logic phase_ok;
  logic [1:0] status;
  logic [pba_pkg::ClassIdxW-1:0] rd_idx, wr_idx;

  assign rd_idx     = pba_pkg::ClassIdxW'(in_data_i.phase);
  assign wr_idx     = pba_pkg::ClassIdxW'(req_q.phase);
  assign phase_ok   = {1'b0, req_q.phase} < 7'(pba_pkg::PhaseClasses);
  assign out_data_o = out_q;

  always_comb begin
    row_cur       = rd_vld_q ? rd_row_q : '0;
    row_cur.stamp = rd_row_q.stamp;
    act_inc       = row_cur.active + 1'b1;
    row_d         = row_cur;
    row_we        = 1'b0;
    vld_clear     = 1'b0;
    status        = pba_pkg::StOk;
    total_d       = total_q;
    busy_stamp_d  = busy_stamp_q;
    busy_acc_d    = busy_acc_q;
    case (req_q.req_type)
      pba_pkg::ReqClear: begin
        vld_clear  = 1'b1;
        row_d      = '0;
        total_d    = '0;
        busy_acc_d = '0;
      end
      pba_pkg::ReqOpen: begin
        if (!phase_ok) begin
          status = pba_pkg::StRange;
        end else if (row_cur.active != pba_pkg::CountMax) begin
          row_we       = 1'b1;
          row_d.active = act_inc;
          if (row_cur.active == '0) row_d.stamp = req_q.timestamp;
          if (act_inc > row_cur.peak) row_d.peak = act_inc;
          if (total_q == '0) busy_stamp_d = req_q.timestamp;
          total_d = total_q + 1'b1;
        end
      end
      pba_pkg::ReqClose: begin
        if (!phase_ok) begin
          status = pba_pkg::StRange;
        end else if (row_cur.active == '0) begin
          status = pba_pkg::StNoOpen;
        end else begin
          row_we       = 1'b1;
          row_d.active = row_cur.active - 1'b1;
          if (row_cur.active == pba_pkg::CountBits'(1)) begin
            row_d.wall = row_cur.wall + pba_pkg::elapsed(row_cur.stamp, req_q.timestamp);
          end
          if (total_q != '0) begin
            total_d = total_q - 1'b1;
            if (total_q == pba_pkg::TotalW'(1)) begin
              busy_acc_d = busy_acc_q + pba_pkg::elapsed(busy_stamp_q, req_q.timestamp);
            end
          end
        end
      end
      pba_pkg::ReqAdd: begin
        if (!phase_ok) begin
          status = pba_pkg::StRange;
        end else begin
          row_we    = 1'b1;
          row_d.cpu = row_cur.cpu + req_q.cpu_amount;
          row_d.run = row_cur.run + 1'b1;
        end
      end
      pba_pkg::ReqRead: begin
        if (!phase_ok) status = pba_pkg::StRange;
      end
      default: ;
    endcase

    out_d.status      = status;
    out_d.cpu_total   = phase_ok ? row_d.cpu : 64'd0;
    out_d.run_total   = phase_ok ? row_d.run : 32'd0;
    out_d.wall_total  = phase_ok ? row_d.wall : 64'd0;
    out_d.peak_active = phase_ok ? pba_pkg::peak_sat(row_d.peak) : 16'd0;
    out_d.busy_total  = busy_acc_d;
    out_d.any_active  = |total_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= in_data_i;
      rd_row_q <= row_mem[rd_idx];
      rd_vld_q <= row_vld_q[rd_idx];
    end
    if (cmd_i.commit && row_we) begin
      row_mem[wr_idx] <= row_d;
    end
    if (cmd_i.commit) begin
      out_q        <= out_d;
      busy_stamp_q <= busy_stamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q  <= '0;
      total_q    <= '0;
      busy_acc_q <= '0;
    end else if (cmd_i.commit) begin
      total_q    <= total_d;
      busy_acc_q <= busy_acc_d;
      if (vld_clear) begin
        row_vld_q <= '0;
      end else if (row_we) begin
        row_vld_q[wr_idx] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for phase_busy_time_accounter: directed table and random open/close/add/read/clear
// and reserved-type traffic; rows not given in the table are checked against an in-bench accounting model.
// Depends on pba_pkg and the RTL of the block only.

module tb;

  localparam logic [2:0] ReqRsvd5 = 3'd5;
  localparam logic [2:0] ReqRsvd6 = 3'd6;
  localparam logic [2:0] ReqRsvd7 = 3'd7;
  localparam int RandomRequests = 1426;

  typedef struct {
    pba_pkg::pba_in_t  rq;
    bit                typed;
    pba_pkg::pba_out_t want;
  } step_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  pba_pkg::pba_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  pba_pkg::pba_out_t out_data_o;

  phase_busy_time_accounter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // accounting model state
  logic [pba_pkg::CountBits-1:0] class_active [pba_pkg::PhaseClasses] = '{default: '0};
  logic [pba_pkg::CountBits-1:0] class_peak   [pba_pkg::PhaseClasses] = '{default: '0};
  logic [63:0]          class_since  [pba_pkg::PhaseClasses] = '{default: '0};
  logic [63:0]          class_wall   [pba_pkg::PhaseClasses] = '{default: '0};
  logic [63:0]          class_cpu    [pba_pkg::PhaseClasses] = '{default: '0};
  logic [31:0]          class_runs   [pba_pkg::PhaseClasses] = '{default: '0};
  logic [pba_pkg::TotalW-1:0] holders = '0;
  logic [63:0]          busy_since = '0;
  logic [63:0]          busy_ns = '0;

  pba_pkg::pba_out_t expected_rows[$];
  int       fails = 0;
  int       drain_wait = 0;
  bit       lazy = 1'b1;
  logic [63:0] clock_ns = '0;

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] span(input logic [63:0] from_ns, input logic [63:0] to_ns);
    return (to_ns > from_ns) ? to_ns - from_ns : 64'd0;
  endfunction

  function automatic pba_pkg::pba_out_t account(input pba_pkg::pba_in_t rq);
    pba_pkg::pba_out_t res;
    int       idx;
    bit       in_range;
    idx = int'(rq.phase);
    in_range = idx < pba_pkg::PhaseClasses;
    res = '0;
    res.status = pba_pkg::StOk;
    if (rq.req_type == pba_pkg::ReqClear) begin
      for (int c = 0; c < pba_pkg::PhaseClasses; c++) begin
        class_active[c] = '0;
        class_peak[c]   = '0;
        class_wall[c]   = '0;
        class_cpu[c]    = '0;
        class_runs[c]   = '0;
      end
      holders = '0;
      busy_ns = '0;
    end else if (rq.req_type <= pba_pkg::ReqRead && !in_range) begin
      res.status = pba_pkg::StRange;
    end else if (rq.req_type == pba_pkg::ReqOpen) begin
      if (class_active[idx] != pba_pkg::CountMax) begin
        if (class_active[idx] == '0) class_since[idx] = rq.timestamp;
        class_active[idx] = class_active[idx] + 1'b1;
        if (class_active[idx] > class_peak[idx]) class_peak[idx] = class_active[idx];
        if (holders == '0) busy_since = rq.timestamp;
        holders = holders + 1'b1;
      end
    end else if (rq.req_type == pba_pkg::ReqClose) begin
      if (class_active[idx] == '0) begin
        res.status = pba_pkg::StNoOpen;
      end else begin
        class_active[idx] = class_active[idx] - 1'b1;
        if (class_active[idx] == '0)
          class_wall[idx] = class_wall[idx] + span(class_since[idx], rq.timestamp);
        if (holders != '0) begin
          holders = holders - 1'b1;
          if (holders == '0) busy_ns = busy_ns + span(busy_since, rq.timestamp);
        end
      end
    end else if (rq.req_type == pba_pkg::ReqAdd) begin
      class_cpu[idx]  = class_cpu[idx] + rq.cpu_amount;
      class_runs[idx] = class_runs[idx] + 1'b1;
    end
    if (in_range) begin
      res.cpu_total   = class_cpu[idx];
      res.run_total   = class_runs[idx];
      res.wall_total  = class_wall[idx];
      res.peak_active = (32'(class_peak[idx]) > 32'hffff) ? 16'hffff : 16'(class_peak[idx]);
    end
    res.busy_total = busy_ns;
    res.any_active = holders != '0;
    return res;
  endfunction

  function automatic pba_pkg::pba_in_t req(input logic [2:0] kind, input int phase,
                                           input logic [63:0] ts, input logic [63:0] amount);
    pba_pkg::pba_in_t rq;
    rq.req_type   = kind;
    rq.phase      = 6'(phase);
    rq.timestamp  = ts;
    rq.cpu_amount = amount;
    return rq;
  endfunction

  function automatic pba_pkg::pba_out_t row_out(input logic [1:0] st, input logic [63:0] cpu,
                                       input logic [31:0] runs, input logic [63:0] wall,
                                       input logic [15:0] peak, input logic [63:0] busy,
                                       input logic any);
    pba_pkg::pba_out_t res;
    res.status      = st;
    res.cpu_total   = cpu;
    res.run_total   = runs;
    res.wall_total  = wall;
    res.peak_active = peak;
    res.busy_total  = busy;
    res.any_active  = any;
    return res;
  endfunction

  function automatic pba_pkg::pba_in_t pick_request();
    pba_pkg::pba_in_t rq;
    int      roll;
    int      open_cls[$];
    roll = $urandom_range(0, 999);
    clock_ns = clock_ns + 64'($urandom_range(0, 2000));
    rq.req_type   = pba_pkg::ReqRead;
    rq.phase      = 6'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0)
      rq.phase = 6'($urandom_range(0, pba_pkg::PhaseClasses - 1));
    rq.timestamp  = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : clock_ns;
    rq.cpu_amount = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                : 64'($urandom_range(0, 5000));
    if (roll < 330) begin
      rq.req_type = pba_pkg::ReqOpen;
    end else if (roll < 660) begin
      rq.req_type = pba_pkg::ReqClose;
      for (int c = 0; c < pba_pkg::PhaseClasses; c++)
        if (class_active[c] != '0) open_cls.push_back(c);
      if (open_cls.size() > 0 && $urandom_range(0, 9) != 0)
        rq.phase = 6'(open_cls[$urandom_range(0, open_cls.size() - 1)]);
    end else if (roll < 800) begin
      rq.req_type = pba_pkg::ReqAdd;
    end else if (roll < 890) begin
      rq.req_type = pba_pkg::ReqRead;
    end else if (roll < 950) begin
      rq.req_type = 3'($urandom_range(pba_pkg::ReqOpen, pba_pkg::ReqRead));
      rq.phase    = 6'($urandom_range(pba_pkg::PhaseClasses, 63));
    end else if (roll < 995) begin
      rq.req_type = 3'($urandom_range(ReqRsvd5, ReqRsvd7));
      rq.phase    = 6'($urandom_range(0, 63));
    end else begin
      rq.req_type = pba_pkg::ReqClear;
      rq.phase    = 6'($urandom_range(0, 63));
    end
    return rq;
  endfunction

  task automatic send(input pba_pkg::pba_in_t rq, input bit typed,
                      input pba_pkg::pba_out_t want);
    pba_pkg::pba_out_t next_out;
    int       gap;
    gap = lazy ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    next_out = account(rq);
    expected_rows.push_back(typed ? want : next_out);
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      if (fails < 10) $display("mismatch %s: expected %h, got %h", what, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    pba_pkg::pba_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      drain_wait = lazy ? $urandom_range(0, 6) : 0;
      if (expected_rows.size() == 0) begin
        if (fails < 10) $display("unexpected result transfer: %h", out_data_o);
        fails++;
      end else begin
        want = expected_rows.pop_front();
        check_field("status", 64'(want.status), 64'(out_data_o.status));
        check_field("cpu_total", want.cpu_total, out_data_o.cpu_total);
        check_field("run_total", 64'(want.run_total), 64'(out_data_o.run_total));
        check_field("wall_total", want.wall_total, out_data_o.wall_total);
        check_field("peak_active", 64'(want.peak_active), 64'(out_data_o.peak_active));
        check_field("busy_total", want.busy_total, out_data_o.busy_total);
        check_field("any_active", 64'(want.any_active), 64'(out_data_o.any_active));
      end
    end
  end

  initial begin : result_stall
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (drain_wait > 0) begin
        out_stall_i <= 1'b1;
        drain_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : run_limit
    #(64'd10_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    step_t       plan[$];
    logic [63:0] ones;
    ones = '1;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    plan.push_back('{req(pba_pkg::ReqRead, 0, 0, 0), 1'b1,
                     row_out(pba_pkg::StOk, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{req(pba_pkg::ReqClose, 5, 0, 0), 1'b1,
                     row_out(pba_pkg::StNoOpen, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{req(pba_pkg::ReqOpen, 40, 7, 0), 1'b1,
                     row_out(pba_pkg::StRange, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{req(pba_pkg::ReqRead, 63, 0, 0), 1'b1,
                     row_out(pba_pkg::StRange, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{req(pba_pkg::ReqAdd, 31, 0, ones), 1'b1,
                     row_out(pba_pkg::StOk, ones, 1, 0, 0, 0, 0)});
    plan.push_back('{req(pba_pkg::ReqAdd, 31, 0, 2), 1'b1,
                     row_out(pba_pkg::StOk, 1, 2, 0, 0, 0, 0)});
    plan.push_back('{req(pba_pkg::ReqAdd, 5, ones, 0), 1'b1,
                     row_out(pba_pkg::StOk, 0, 1, 0, 0, 0, 0)});
    plan.push_back('{req(ReqRsvd5, 50, 0, 0), 1'b1,
                     row_out(pba_pkg::StOk, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{req(ReqRsvd7, 31, 0, 0), 1'b1,
                     row_out(pba_pkg::StOk, 1, 2, 0, 0, 0, 0)});
    plan.push_back('{req(ReqRsvd6, 0, ones, ones), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqOpen, 0, 100, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqOpen, 0, 150, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqOpen, 31, 200, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqClose, 0, 250, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqClose, 0, 300, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqClose, 31, 50, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqOpen, 1, 0, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqClose, 1, ones, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqOpen, 1, 0, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqClose, 1, 2, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqClose, 31, 400, 0), 1'b0, '0});
    plan.push_back('{req(pba_pkg::ReqClear, 63, 0, 0), 1'b1,
                     row_out(pba_pkg::StOk, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{req(pba_pkg::ReqRead, 31, 0, 0), 1'b1,
                     row_out(pba_pkg::StOk, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{req(pba_pkg::ReqClear, 3, 0, 0), 1'b1,
                     row_out(pba_pkg::StOk, 0, 0, 0, 0, 0, 0)});
    foreach (plan[i]) send(plan[i].rq, plan[i].typed, plan[i].want);

    for (int n = 0; n < RandomRequests; n++) begin
      if (n % 150 == 0) lazy = $urandom_range(0, 3) != 0;
      send(pick_request(), 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    lazy = 1'b1;

    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pba_pkg.sv
hw/rtl/pba_ctrl.sv
hw/rtl/pba_datapath.sv
hw/rtl/phase_busy_time_accounter.sv
tb/sv/tb.sv
